[hdl/ptgf_pkg.sv]
// shared types and constants for the palette table with gradient fill
// no dependencies
package ptgf_pkg;

    localparam int DEPTH_DEF   = 256;
    localparam int RESET_COUNT = 256;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 3 * CHAN_W;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_GRAD  = 2'd2,
        REQ_MAX   = 2'd3
    } req_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_GRAD,
        ST_SCAN,
        ST_RESP
    } state_e;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] index_a;
        logic [7:0] index_b;
        logic [7:0] red_a;
        logic [7:0] green_a;
        logic [7:0] blue_a;
        logic [7:0] red_b;
        logic [7:0] green_b;
        logic [7:0] blue_b;
        logic       invert_end;
    } in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] max_channel;
        logic       status;
    } out_t;

    typedef struct packed {
        logic load;
        logic step;
    } lerp_ctrl_t;

endpackage

[hdl/ptgf_lerp.sv]
// one color channel of the gradient: serial divider for the slope, then
// an accumulating stepper that advances one position per step
// depends on ptgf_pkg
module ptgf_lerp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptgf_pkg::lerp_ctrl_t ctrl,
    input  logic [7:0]           start_val,
    input  logic [7:0]           end_val,
    input  logic [7:0]           span,
    output logic [7:0]           value,
    output logic                 busy
);

    logic       busy_reg, busy_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       neg_reg, neg_next;
    logic [7:0] span_reg, span_next;
    logic [7:0] dq_reg, dq_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] v_reg, v_next;
    logic [7:0] r_reg, r_next;
    logic [7:0] qd_reg, qd_next;
    logic [7:0] rd_reg, rd_next;

    logic [8:0] diff;
    logic [8:0] rem_sh;
    logic       ge;
    logic [7:0] rem_new;
    logic [7:0] dq_new;
    logic [8:0] sum;
    logic       carry;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        span_next = span_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        qd_next   = qd_reg;
        rd_next   = rd_reg;

        diff    = {1'b0, end_val} - {1'b0, start_val};
        rem_sh  = {rem_reg, dq_reg[7]};
        ge      = rem_sh >= {1'b0, span_reg};
        rem_new = ge ? 8'(rem_sh - {1'b0, span_reg}) : rem_sh[7:0];
        dq_new  = {dq_reg[6:0], ge};
        sum     = {1'b0, r_reg} + {1'b0, rd_reg};
        carry   = sum >= {1'b0, span_reg};

        if (ctrl.load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = diff[8];
            span_next = span;
            dq_next   = diff[8] ? 8'(-diff) : diff[7:0];
            rem_next  = '0;
            v_next    = start_val;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            // restoring division of |end - start| by span, one bit a cycle
            dq_next  = dq_new;
            rem_next = rem_new;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                // floor division for a negative slope
                if (!neg_reg)
                begin
                    qd_next = dq_new;
                    rd_next = rem_new;
                end
                else if (rem_new != '0)
                begin
                    qd_next = ~dq_new;
                    rd_next = span_reg - rem_new;
                end
                else
                begin
                    qd_next = 8'(-dq_new);
                    rd_next = '0;
                end
            end
        end
        else if (ctrl.step)
        begin
            r_next = carry ? 8'(sum - {1'b0, span_reg}) : sum[7:0];
            v_next = v_reg + qd_reg + {7'd0, carry};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        span_reg <= span_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        qd_reg   <= qd_next;
        rd_reg   <= rd_next;
    end

    assign value = v_reg;
    assign busy  = busy_reg;

endmodule

[hdl/palette_table_gradient_fill_top.sv]
// top level of the palette table: request sequencer, palette memory and
// three gradient channel units
// depends on ptgf_pkg and ptgf_lerp
//
// Requests arrive on in_valid/in_ready/in_data, results leave on
// out_valid/out_ready/out_data, one result per request. cfg_we/cfg_wdata
// set the number of entries in use; entries at and above the new count are
// cleared by a background sweep.
// A gradient runs the 8 step slope divider, hands over to the channel
// stepping, then makes one memory write per position. A max query makes
// one memory read per entry in use, then takes the last read data and
// the final compare.
// After reset the memory is swept to black with in_ready low. A finished
// result sits in the output register until taken; the next request is
// accepted meanwhile, and its result waits in the sequencer until the
// output register frees up.
module palette_table_gradient_fill_top #(
    parameter int TABLE_DEPTH = ptgf_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ptgf_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ptgf_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [8:0]     cfg_wdata
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int PTR_W  = ADDR_W + 1;

    logic [ptgf_pkg::COLOR_W-1:0] mem [TABLE_DEPTH];
    logic [ptgf_pkg::COLOR_W-1:0] mem_rdata_reg;

    ptgf_pkg::state_e state_reg, state_next;
    logic [PTR_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] clr_ptr_reg, clr_ptr_next;
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [7:0]       max_reg, max_next;
    logic [7:0]       grad_ptr_reg, grad_ptr_next;
    ptgf_pkg::in_t    req_reg, req_next;
    ptgf_pkg::out_t   res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    ptgf_pkg::out_t   out_data_reg, out_data_next;

    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [ADDR_W-1:0]            mem_raddr;
    logic [ptgf_pkg::COLOR_W-1:0] mem_wdata;

    ptgf_pkg::lerp_ctrl_t lerp_ctrl;
    logic [7:0]           end_r, end_g, end_b;
    logic [7:0]           val_r, val_g, val_b;
    logic                 busy_r, busy_g, busy_b;

    logic             clr_active;
    logic             accept;
    logic             slot_free;
    logic             a_in_range;
    logic             grad_ok;
    logic [PTR_W-1:0] cfg_eff;
    logic [7:0]       m_rg, m_b;

    assign clr_active = 32'(clr_ptr_reg) < 32'(TABLE_DEPTH);
    assign in_ready   = (state_reg == ptgf_pkg::ST_IDLE) && !clr_active;
    assign accept     = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign a_in_range = 32'(in_data.index_a) < 32'(cnt_reg);
    assign grad_ok    = (in_data.index_a < in_data.index_b)
                        && (32'(in_data.index_b) < 32'(cnt_reg));
    assign cfg_eff    = (32'(cfg_wdata) > 32'(TABLE_DEPTH)) ? PTR_W'(TABLE_DEPTH)
                                                           : PTR_W'(cfg_wdata);

    assign end_r = in_data.invert_end ? ~in_data.red_a   : in_data.red_b;
    assign end_g = in_data.invert_end ? ~in_data.green_a : in_data.green_b;
    assign end_b = in_data.invert_end ? ~in_data.blue_a  : in_data.blue_b;

    ptgf_lerp u_lerp_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lerp_ctrl),
        .start_val (in_data.red_a),
        .end_val   (end_r),
        .span      (in_data.index_b - in_data.index_a),
        .value     (val_r),
        .busy      (busy_r)
    );

    ptgf_lerp u_lerp_g (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lerp_ctrl),
        .start_val (in_data.green_a),
        .end_val   (end_g),
        .span      (in_data.index_b - in_data.index_a),
        .value     (val_g),
        .busy      (busy_g)
    );

    ptgf_lerp u_lerp_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lerp_ctrl),
        .start_val (in_data.blue_a),
        .end_val   (end_b),
        .span      (in_data.index_b - in_data.index_a),
        .value     (val_b),
        .busy      (busy_b)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptgf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (ptgf_pkg::req_e'(in_data.req_type))
                        ptgf_pkg::REQ_READ:
                            state_next = a_in_range ? ptgf_pkg::ST_READ : ptgf_pkg::ST_RESP;
                        ptgf_pkg::REQ_WRITE:
                            state_next = ptgf_pkg::ST_RESP;
                        ptgf_pkg::REQ_GRAD:
                            state_next = grad_ok ? ptgf_pkg::ST_DIV : ptgf_pkg::ST_RESP;
                        ptgf_pkg::REQ_MAX:
                            state_next = ptgf_pkg::ST_SCAN;
                        default:
                            state_next = ptgf_pkg::ST_RESP;
                    endcase
                end
            end
            ptgf_pkg::ST_READ:
                state_next = ptgf_pkg::ST_RESP;
            ptgf_pkg::ST_DIV:
                if (!(busy_r || busy_g || busy_b))
                    state_next = ptgf_pkg::ST_GRAD;
            ptgf_pkg::ST_GRAD:
                if (grad_ptr_reg == req_reg.index_b)
                    state_next = ptgf_pkg::ST_RESP;
            ptgf_pkg::ST_SCAN:
                if ((scan_ptr_reg >= cnt_reg) && !rd_vld_reg)
                    state_next = ptgf_pkg::ST_RESP;
            ptgf_pkg::ST_RESP:
                if (slot_free)
                    state_next = ptgf_pkg::ST_IDLE;
            default:
                state_next = ptgf_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cnt_next       = cnt_reg;
        clr_ptr_next   = clr_ptr_reg;
        scan_ptr_next  = scan_ptr_reg;
        rd_vld_next    = 1'b0;
        max_next       = max_reg;
        grad_ptr_next  = grad_ptr_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = ADDR_W'(in_data.index_a);
        mem_wdata      = {in_data.red_a, in_data.green_a, in_data.blue_a};
        mem_raddr      = ADDR_W'(in_data.index_a);
        lerp_ctrl      = '0;
        m_rg           = '0;
        m_b            = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ptgf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = in_data;
                    res_next = '0;
                    unique case (ptgf_pkg::req_e'(in_data.req_type))
                        ptgf_pkg::REQ_READ:
                            res_next.status = !a_in_range;
                        ptgf_pkg::REQ_WRITE:
                        begin
                            mem_we          = a_in_range;
                            res_next.status = !a_in_range;
                        end
                        ptgf_pkg::REQ_GRAD:
                        begin
                            lerp_ctrl.load  = grad_ok;
                            grad_ptr_next   = in_data.index_a;
                            res_next.status = !grad_ok;
                        end
                        ptgf_pkg::REQ_MAX:
                        begin
                            scan_ptr_next = '0;
                            max_next      = '0;
                        end
                        default:
                            res_next.status = 1'b1;
                    endcase
                end
            end
            ptgf_pkg::ST_READ:
            begin
                res_next.red_out   = mem_rdata_reg[23:16];
                res_next.green_out = mem_rdata_reg[15:8];
                res_next.blue_out  = mem_rdata_reg[7:0];
            end
            ptgf_pkg::ST_DIV:
            begin
            end
            ptgf_pkg::ST_GRAD:
            begin
                mem_we         = 1'b1;
                mem_waddr      = ADDR_W'(grad_ptr_reg);
                mem_wdata      = {val_r, val_g, val_b};
                lerp_ctrl.step = 1'b1;
                grad_ptr_next  = grad_ptr_reg + 8'd1;
            end
            ptgf_pkg::ST_SCAN:
            begin
                if (scan_ptr_reg < cnt_reg)
                begin
                    mem_raddr     = ADDR_W'(scan_ptr_reg);
                    scan_ptr_next = scan_ptr_reg + PTR_W'(1);
                    rd_vld_next   = 1'b1;
                end
                // read data arrives in the cycle after its address
                if (rd_vld_reg)
                begin
                    m_rg = (mem_rdata_reg[23:16] > mem_rdata_reg[15:8])
                           ? mem_rdata_reg[23:16] : mem_rdata_reg[15:8];
                    m_b  = (mem_rdata_reg[7:0] > max_reg) ? mem_rdata_reg[7:0] : max_reg;
                    max_next = (m_rg > m_b) ? m_rg : m_b;
                end
                res_next.max_channel = max_reg;
            end
            ptgf_pkg::ST_RESP:
            begin
                if (slot_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (clr_active)
        begin
            mem_we       = 1'b1;
            mem_waddr    = ADDR_W'(clr_ptr_reg);
            mem_wdata    = '0;
            clr_ptr_next = clr_ptr_reg + PTR_W'(1);
        end

        if (cfg_we)
        begin
            cnt_next = cfg_eff;
            // a sweep still running keeps its lower start point
            if (clr_active && (clr_ptr_next < cfg_eff))
                clr_ptr_next = clr_ptr_next;
            else
                clr_ptr_next = cfg_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptgf_pkg::ST_IDLE;
            cnt_reg       <= (ptgf_pkg::RESET_COUNT > TABLE_DEPTH)
                             ? PTR_W'(TABLE_DEPTH) : PTR_W'(ptgf_pkg::RESET_COUNT);
            clr_ptr_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_ptr_reg   <= clr_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_ptr_reg <= scan_ptr_next;
        max_reg      <= max_next;
        grad_ptr_reg <= grad_ptr_next;
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_grad_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ptgf_pkg::ST_GRAD |-> 32'(grad_ptr_reg) < 32'(cnt_reg))
        else $error("gradient write beyond entries in use");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ptgf_pkg::ST_SCAN |-> scan_ptr_reg <= cnt_reg)
        else $error("scan pointer past entries in use");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active |-> state_reg == ptgf_pkg::ST_IDLE && !in_ready)
        else $error("request activity during clearing sweep");

    a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ptgf_pkg::ST_RESP && slot_free |=> out_valid_reg)
        else $error("result not loaded into output register");

endmodule
